/* design/mtll_pkg.sv */
package mtll_pkg;

	// Input item kinds; code 3 is ignored
	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_SEEK_AMPS           = 3'd0;
	localparam logic [2:0] REG_STALL_SPEED_LIMIT   = 3'd1;
	localparam logic [2:0] REG_STALL_CURRENT_LIMIT = 3'd2;
	localparam logic [2:0] REG_STALL_CONFIRM_TIME  = 3'd3;
	localparam logic [2:0] REG_SETTLE_SPEED_LIMIT  = 3'd4;
	localparam logic [2:0] REG_SETTLE_TIME         = 3'd5;
	localparam logic [2:0] REG_SEEK_TIMEOUT        = 3'd6;
	localparam logic [2:0] REG_MIN_SPAN            = 3'd7;

	// Fixed behavior of the return-to-center move
	localparam bit          RETURN_ENABLE    = 1'b1;
	localparam logic [31:0] RETURN_LIMIT_MS  = 32'd3000;
	localparam logic [33:0] CENTER_TOLERANCE = 34'd3277;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SEEK_MIN,
		PH_SETTLE,
		PH_SEEK_MAX,
		PH_RETURN,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [2:0] {
		ST_RUNNING,
		ST_PASS,
		ST_OFFLINE,
		ST_FEEDBACK,
		ST_TIMEOUT,
		ST_RANGE,
		ST_NOT_STARTED
	} status_t;

	typedef enum logic [1:0] {
		DM_NONE,
		DM_CURRENT,
		DM_POSITION,
		DM_RELAX
	} drive_mode_t;

	typedef struct packed {
		logic [30:0] seek_amps;
		logic [30:0] stall_speed_limit;
		logic [30:0] stall_current_limit;
		logic [31:0] stall_confirm_time;
		logic [30:0] settle_speed_limit;
		logic [31:0] settle_time;
		logic [31:0] seek_timeout;
		logic [30:0] min_span;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] now_time;
		logic        motor_online;
		logic        feedback_ok;
		logic [31:0] position;
		logic [31:0] velocity;
		logic [31:0] torque_current;
	} item_t;

	typedef struct packed {
		drive_mode_t drive_mode;
		logic [31:0] drive_current;
		logic [31:0] drive_target;
		status_t     status;
		logic        learned;
		logic [31:0] low_end;
		logic [31:0] high_end;
	} result_t;

endpackage

/* design/mtll_ctrl.sv */
module mtll_ctrl import mtll_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	phase_t             phase_q, phase_d;
	status_t            outcome_q, outcome_d;
	logic [31:0]        phase_start_q, phase_start_d;
	logic [31:0]        stall_start_q, stall_start_d;
	logic [31:0]        settle_start_q, settle_start_d;
	logic signed [31:0] min_q, min_d;
	logic signed [31:0] max_q, max_d;
	logic               learned_q, learned_d;

	logic signed [31:0] pos;
	logic [31:0]        vel_mag;
	logic [31:0]        cur_mag;
	logic [31:0]        now;
	logic               stall_cond;
	logic [31:0]        stall_base;
	logic               stall_done;
	logic               settle_cond;
	logic [31:0]        settle_base;
	logic               settle_done;
	logic [31:0]        phase_elapsed;
	logic signed [32:0] span;
	logic               span_short;
	logic signed [32:0] mid_sum;
	logic signed [31:0] mid;
	logic signed [33:0] cdiff;
	logic               center_ok;
	logic [31:0]        seek32;

	assign now     = item.now_time;
	assign pos     = $signed(item.position);
	assign vel_mag = item.velocity[31] ? (~item.velocity + 32'd1) : item.velocity;
	assign cur_mag = item.torque_current[31] ? (~item.torque_current + 32'd1)
		: item.torque_current;

	assign stall_cond = (vel_mag <= {1'b0, cfg.stall_speed_limit}) &&
		(cur_mag >= {1'b0, cfg.stall_current_limit});
	assign stall_base = (stall_start_q == 32'd0) ? now : stall_start_q;
	assign stall_done = (now - stall_base) >= cfg.stall_confirm_time;

	assign settle_cond = vel_mag <= {1'b0, cfg.settle_speed_limit};
	assign settle_base = (settle_start_q == 32'd0) ? now : settle_start_q;
	assign settle_done = (now - settle_base) >= cfg.settle_time;

	assign phase_elapsed = now - phase_start_q;

	assign span       = {pos[31], pos} - {min_q[31], min_q};
	assign span_short = span < $signed({2'b00, cfg.min_span});

	// floor of the average without overflow
	assign mid_sum   = {min_q[31], min_q} + {max_q[31], max_q};
	assign mid       = mid_sum[32:1];
	assign cdiff     = {{2{pos[31]}}, pos} - {{2{mid[31]}}, mid};
	assign center_ok = (cdiff <= $signed(CENTER_TOLERANCE)) &&
		(cdiff >= -$signed(CENTER_TOLERANCE));

	assign seek32 = {1'b0, cfg.seek_amps};

	always_comb begin
		phase_d        = phase_q;
		outcome_d      = outcome_q;
		phase_start_d  = phase_start_q;
		stall_start_d  = stall_start_q;
		settle_start_d = settle_start_q;
		min_d          = min_q;
		max_d          = max_q;
		learned_d      = learned_q;
		res.drive_mode    = DM_NONE;
		res.drive_current = 32'd0;
		res.drive_target  = 32'd0;

		case (item.kind)
			KIND_START: begin
				min_d          = 32'sd0;
				max_d          = 32'sd0;
				learned_d      = 1'b0;
				stall_start_d  = 32'd0;
				settle_start_d = 32'd0;
				outcome_d      = ST_RUNNING;
				phase_d        = PH_SEEK_MIN;
				phase_start_d  = now;
			end
			KIND_CANCEL: begin
				res.drive_mode = DM_RELAX;
				phase_d        = PH_IDLE;
				outcome_d      = ST_RANGE;
			end
			KIND_TICK: begin
				if (outcome_q == ST_RUNNING) begin
					if (!item.motor_online) begin
						outcome_d      = ST_OFFLINE;
						phase_d        = PH_ERROR;
						res.drive_mode = DM_RELAX;
					end else if (!item.feedback_ok) begin
						outcome_d      = ST_FEEDBACK;
						phase_d        = PH_ERROR;
						res.drive_mode = DM_RELAX;
					end else begin
						case (phase_q)
							PH_SEEK_MIN, PH_SEEK_MAX: begin
								res.drive_mode    = DM_CURRENT;
								res.drive_current = (phase_q == PH_SEEK_MIN)
									? (~seek32 + 32'd1) : seek32;
								stall_start_d = stall_cond ? stall_base : 32'd0;
								if (stall_cond && stall_done) begin
									res.drive_mode    = DM_RELAX;
									res.drive_current = 32'd0;
									if (phase_q == PH_SEEK_MIN) begin
										min_d          = pos;
										phase_d        = PH_SETTLE;
										phase_start_d  = now;
										stall_start_d  = 32'd0;
										settle_start_d = 32'd0;
									end else begin
										max_d = pos;
										if (span_short) begin
											outcome_d = ST_RANGE;
											phase_d   = PH_ERROR;
										end else begin
											learned_d = 1'b1;
											if (RETURN_ENABLE) begin
												phase_d        = PH_RETURN;
												phase_start_d  = now;
												stall_start_d  = 32'd0;
												settle_start_d = 32'd0;
											end else begin
												outcome_d = ST_PASS;
												phase_d   = PH_DONE;
											end
										end
									end
								end else if (phase_elapsed >= cfg.seek_timeout) begin
									outcome_d         = ST_TIMEOUT;
									phase_d           = PH_ERROR;
									res.drive_mode    = DM_RELAX;
									res.drive_current = 32'd0;
								end
							end
							PH_SETTLE: begin
								settle_start_d = settle_cond ? settle_base : 32'd0;
								if (settle_cond && settle_done) begin
									phase_d        = PH_SEEK_MAX;
									phase_start_d  = now;
									stall_start_d  = 32'd0;
									settle_start_d = 32'd0;
								end
							end
							PH_RETURN: begin
								res.drive_mode   = DM_POSITION;
								res.drive_target = mid;
								if (center_ok) begin
									outcome_d        = ST_PASS;
									phase_d          = PH_DONE;
									res.drive_mode   = DM_RELAX;
									res.drive_target = 32'd0;
								end else if (phase_elapsed >= RETURN_LIMIT_MS) begin
									outcome_d        = ST_TIMEOUT;
									phase_d          = PH_ERROR;
									res.drive_mode   = DM_RELAX;
									res.drive_target = 32'd0;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			default: begin
			end
		endcase

		res.status   = outcome_d;
		res.learned  = learned_d;
		res.low_end  = min_d;
		res.high_end = max_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			outcome_q      <= ST_NOT_STARTED;
			phase_start_q  <= 32'd0;
			stall_start_q  <= 32'd0;
			settle_start_q <= 32'd0;
			min_q          <= 32'sd0;
			max_q          <= 32'sd0;
			learned_q      <= 1'b0;
		end else if (advance) begin
			phase_q        <= phase_d;
			outcome_q      <= outcome_d;
			phase_start_q  <= phase_start_d;
			stall_start_q  <= stall_start_d;
			settle_start_q <= settle_start_d;
			min_q          <= min_d;
			max_q          <= max_d;
			learned_q      <= learned_d;
		end
	end

	a_start_enters_seek: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.kind == KIND_START |=>
			outcome_q == ST_RUNNING && phase_q == PH_SEEK_MIN && !learned_q)
		else $error("start did not enter the minimum seek");

	a_running_phase: assert property (@(posedge clk) disable iff (!arst_n)
		outcome_q == ST_RUNNING |->
			phase_q == PH_SEEK_MIN || phase_q == PH_SETTLE ||
			phase_q == PH_SEEK_MAX || phase_q == PH_RETURN)
		else $error("running outcome outside an active phase");

	a_done_is_pass: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |-> outcome_q == ST_PASS && learned_q)
		else $error("done phase without a pass");

	a_hold_without_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(outcome_q) && $stable(min_q) &&
			$stable(max_q))
		else $error("state changed without an item");

endmodule

/* design/motor_travel_limit_learner.sv */
// An accepted item is held in the item register; once the result register is free,
// its result is registered there and result_valid rises with it.
// Throughput: one item per cycle while the result register is not stalled; the whole
// control step is one pass of logic between the item register and the result register.
// Reset (arst_n low, asynchronous): phase idle, status not started, learned ends and
// timers cleared, configuration at its documented defaults, both channels empty.
module motor_travel_limit_learner import mtll_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,

	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] now_time,
	input  logic        motor_online,
	input  logic        feedback_ok,
	input  logic signed [31:0] position,
	input  logic signed [31:0] velocity,
	input  logic signed [31:0] torque_current,

	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  drive_mode,
	output logic signed [31:0] drive_current,
	output logic signed [31:0] drive_target,
	output logic [2:0]  status,
	output logic        learned,
	output logic signed [31:0] low_end,
	output logic signed [31:0] high_end
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    out_free;
	logic    advance;
	logic    item_take;

	// Always writable; writes must arrive only while the block is idle, unchecked.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seek_amps           <= 31'd65536;
			cfg_q.stall_speed_limit   <= 31'd6554;
			cfg_q.stall_current_limit <= 31'd52429;
			cfg_q.stall_confirm_time  <= 32'd100;
			cfg_q.settle_speed_limit  <= 31'd3277;
			cfg_q.settle_time         <= 32'd200;
			cfg_q.seek_timeout        <= 32'd5000;
			cfg_q.min_span            <= 31'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEEK_AMPS:           cfg_q.seek_amps           <= cfg_data[30:0];
				REG_STALL_SPEED_LIMIT:   cfg_q.stall_speed_limit   <= cfg_data[30:0];
				REG_STALL_CURRENT_LIMIT: cfg_q.stall_current_limit <= cfg_data[30:0];
				REG_STALL_CONFIRM_TIME:  cfg_q.stall_confirm_time  <= cfg_data;
				REG_SETTLE_SPEED_LIMIT:  cfg_q.settle_speed_limit  <= cfg_data[30:0];
				REG_SETTLE_TIME:         cfg_q.settle_time         <= cfg_data;
				REG_SEEK_TIMEOUT:        cfg_q.seek_timeout        <= cfg_data;
				REG_MIN_SPAN:            cfg_q.min_span            <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// The result register is free when empty or being drained this cycle.
	// Advance the held item into the controller only then; otherwise hold it
	// and stall the item channel.
	assign out_free   = !valid_s2 || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign item_take  = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input stage: load on every accepted transaction.
	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1.kind           <= kind;
			item_s1.now_time       <= now_time;
			item_s1.motor_online   <= motor_online;
			item_s1.feedback_ok    <= feedback_ok;
			item_s1.position       <= position;
			item_s1.velocity       <= velocity;
			item_s1.torque_current <= torque_current;
		end
	end

	// Homing sequencer: phase state, stall and settle timers, learned ends.
	mtll_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register: hold while the consumer stalls.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign result_valid  = valid_s2;
	assign drive_mode    = res_s2.drive_mode;
	assign drive_current = res_s2.drive_current;
	assign drive_target  = res_s2.drive_target;
	assign status        = res_s2.status;
	assign learned       = res_s2.learned;
	assign low_end       = res_s2.low_end;
	assign high_end      = res_s2.high_end;

endmodule
